[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the RTL. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/ggx_pkg.sv]
// ----------------------------------------------------------------------------
// ggx_pkg
// Shared constants, types and helper functions of the GGX hemisphere sampler.
// ----------------------------------------------------------------------------
package ggx_pkg;

  localparam logic [16:0] ONE_IN   = 17'h10000;
  localparam logic [15:0] ONE_OUT  = 16'h8000;
  localparam logic [14:0] YMAX     = 15'h7FFF;
  localparam logic [30:0] ONE_TRIG = 31'h40000000;
  localparam logic [30:0] ONE_SQ   = 31'h40000000;
  localparam logic [32:0] TWO_PI   = 33'd6746518852;

  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;
  localparam int HORNER     = 6;
  localparam int SIDE_W     = 32;

  // accept to result strobe: front 3, divider, root, cos square, root,
  // angle fold, x squared, series, product, saturate
  localparam int LATENCY = 3 + DIV_STEPS + SQRT_STEPS + 1 + SQRT_STEPS + 2
                         + 2 * HORNER + 2;

  // exact floor division by reciprocal multiply for operands below 2^30
  localparam int unsigned SIN_K [0:4] = '{37, 37, 36, 35, 33};
  localparam int unsigned COS_K [0:5] = '{38, 37, 36, 35, 34, 31};
  localparam logic [31:0] SIN_M [0:4] = '{
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam logic [31:0] COS_M [0:5] = '{
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  typedef struct packed {
    logic [31:0] v;
    logic [31:0] r;
  } sq_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic        swap;
    logic [1:0]  quad;
    logic [15:0] sinq;
    logic [14:0] ycl;
  } trig_side_t;

  function automatic sq_t sqrt_step(input logic [31:0] v, input logic [31:0] r,
                                    input logic [31:0] b);
    logic [31:0] sum;
    sq_t         res;
    sum = r + b;
    if (v >= sum) begin
      res.v = v - sum;
      res.r = (r >> 1) + b;
    end else begin
      res.v = v;
      res.r = r >> 1;
    end
    return res;
  endfunction

  // round half away from zero to Q1.15 and saturate
  function automatic logic [15:0] sat_out(input logic [46:0] prod, input logic neg);
    logic [46:0] sum;
    logic [16:0] p;
    logic [15:0] res;
    sum = prod + 47'h20000000;
    p   = sum[46:30];
    if (!neg) begin
      res = (p > 17'h07FFF) ? 16'h7FFF : p[15:0];
    end else begin
      res = (p >= 17'h08000) ? 16'h8000 : 16'(17'd0 - p);
    end
    return res;
  endfunction

endpackage

[hw/rtl/ggx_isqrt.sv]
// ----------------------------------------------------------------------------
// ggx_isqrt
// Pipelined integer square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module ggx_isqrt import ggx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_v,
  input  logic [31:0]       in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_v,
  output logic [15:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic              sv   [0:SQRT_STEPS];
  logic [31:0]       sval [0:SQRT_STEPS];
  logic [31:0]       sr   [0:SQRT_STEPS];
  logic [SIDE_W-1:0] ss   [0:SQRT_STEPS];

  assign sv[0]   = in_v;
  assign sval[0] = in_val;
  assign sr[0]   = 32'd0;
  assign ss[0]   = in_side;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    sq_t nxt;
    always_comb begin
      nxt = sqrt_step(sval[j], sr[j], 32'd1 << (30 - 2 * j));
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else begin
        sv[j+1] <= sv[j];
      end
    end
    always_ff @(posedge clk) begin
      sval[j+1] <= nxt.v;
      sr[j+1]   <= nxt.r;
      ss[j+1]   <= ss[j];
    end
  end

  assign out_v    = sv[SQRT_STEPS];
  assign out_root = sr[SQRT_STEPS][15:0];
  assign out_side = ss[SQRT_STEPS];

endmodule

[hw/rtl/ggx_hemisphere_sampler.sv]
// ----------------------------------------------------------------------------
// ggx_hemisphere_sampler
// GGX importance sampling of a direction over the upper hemisphere.
// ----------------------------------------------------------------------------
// Takes one word per clock: busy stays low, so every start is accepted. Each
// result appears on dir_x/dir_y/dir_z with done high for one cycle; the
// receiver must take it then. The main sections of the pipeline are the
// 31-stage restoring divider, two 16-stage square root pipelines and the
// 12-stage sine/cosine series; throughput is one word a cycle.
module ggx_hemisphere_sampler import ggx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        rand_angle,
  input  logic [16:0]        rand_height,
  input  logic [16:0]        surface_roughness,
  output logic               done,
  output logic signed [15:0] dir_x,
  output logic [14:0]        dir_y,
  output logic signed [15:0] dir_z
);

  `include "assert_macros.svh"

  assign busy = 1'b0;

  // ---- front: alpha, alpha^2, numerator and denominator
  logic [16:0] r2c, gc;
  logic [33:0] gg;
  logic        s1_v, s2_v, s3_v;
  logic [16:0] s1_r2, s1_a, s2_r2, s2_a2, s3_num, s3_den;
  logic [15:0] s1_ang, s2_ang, s3_ang;
  logic [33:0] aa, dprod;
  logic [16:0] den_c;

  always_comb begin
    r2c   = (rand_height > ONE_IN) ? ONE_IN : rand_height;
    gc    = (surface_roughness > ONE_IN) ? ONE_IN : surface_roughness;
    gg    = gc * gc;
    aa    = s1_a * s1_a;
    dprod = (ONE_IN - s2_a2) * s2_r2;
    den_c = ONE_IN - dprod[32:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= start & ~busy;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_r2  <= r2c;
    s1_a   <= gg[32:16];
    s1_ang <= rand_angle;
    s2_r2  <= s1_r2;
    s2_a2  <= aa[32:16];
    s2_ang <= s1_ang;
    s3_num <= ONE_IN - s2_r2;
    s3_den <= den_c;
    s3_ang <= s2_ang;
  end

  // ---- restoring divider, one quotient bit per stage
  logic        dv   [0:DIV_STEPS];
  logic [17:0] dr   [0:DIV_STEPS];
  logic [30:0] dq   [0:DIV_STEPS];
  logic [16:0] dd   [0:DIV_STEPS];
  logic        dz   [0:DIV_STEPS];
  logic [15:0] dang [0:DIV_STEPS];

  assign dv[0]   = s3_v;
  assign dr[0]   = {1'b0, s3_num};
  assign dq[0]   = 31'd0;
  assign dd[0]   = s3_den;
  assign dz[0]   = (s3_den == 17'd0);
  assign dang[0] = s3_ang;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [17:0] rs, rn;
    logic        qb;
    always_comb begin
      if (k == 0) begin
        rs = dr[k];
      end else begin
        rs = {dr[k][16:0], 1'b0};
      end
      qb = (rs >= {1'b0, dd[k]});
      rn = qb ? rs - {1'b0, dd[k]} : rs;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      dr[k+1]   <= rn;
      dq[k+1]   <= {dq[k][29:0], qb};
      dd[k+1]   <= dd[k];
      dz[k+1]   <= dz[k];
      dang[k+1] <= dang[k];
    end
  end

  // ---- cos_theta
  logic              q1_v;
  logic [15:0]       root1;
  logic [SIDE_W-1:0] side1;

  ggx_isqrt u_sqrt_cos (
    .clk      (clk),
    .rst      (rst),
    .in_v     (dv[DIV_STEPS]),
    .in_val   ({1'b0, dq[DIV_STEPS]}),
    .in_side  ({15'd0, dz[DIV_STEPS], dang[DIV_STEPS]}),
    .out_v    (q1_v),
    .out_root (root1),
    .out_side (side1)
  );

  logic [15:0] cosq;
  logic [31:0] cc;
  logic        c_v;
  logic [30:0] c_s2;
  logic [14:0] c_ycl;
  logic [15:0] c_ang;

  always_comb begin
    if (side1[16]) begin
      cosq = ONE_OUT;
    end else begin
      cosq = (root1 > ONE_OUT) ? ONE_OUT : root1;
    end
    cc = cosq * cosq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= q1_v;
    end
  end

  // sin_theta takes the saturated cos_theta
  always_ff @(posedge clk) begin
    c_s2  <= ONE_SQ - cc[30:0];
    c_ycl <= (cosq >= ONE_OUT) ? YMAX : cosq[14:0];
    c_ang <= side1[15:0];
  end

  // ---- sin_theta
  logic              q2_v;
  logic [15:0]       sinq;
  logic [SIDE_W-1:0] side2;

  ggx_isqrt u_sqrt_sin (
    .clk      (clk),
    .rst      (rst),
    .in_v     (c_v),
    .in_val   ({1'b0, c_s2}),
    .in_side  ({1'b0, c_ycl, c_ang}),
    .out_v    (q2_v),
    .out_root (sinq),
    .out_side (side2)
  );

  // ---- fold angle into the first octant, radian value
  logic [14:0] tf;
  logic        tswap;
  logic [47:0] xp;
  logic        t0_v, t1_v;
  trig_side_t  t0;
  logic [59:0] xx;

  always_comb begin
    tswap = (side2[13:0] > 14'h2000);
    tf    = tswap ? 15'h4000 - {1'b0, side2[13:0]} : {1'b0, side2[13:0]};
    xp    = tf * TWO_PI + 48'h8000;
    xx    = t0.x * t0.x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
      t1_v <= 1'b0;
    end else begin
      t0_v <= q2_v;
      t1_v <= t0_v;
    end
  end

  always_ff @(posedge clk) begin
    t0.x    <= xp[45:16];
    t0.x2   <= 30'd0;
    t0.swap <= tswap;
    t0.quad <= side2[15:14];
    t0.sinq <= sinq;
    t0.ycl  <= side2[30:16];
  end

  // ---- series by Horner, sine and cosine side by side
  logic        hv    [0:HORNER];
  trig_side_t  hside [0:HORNER];
  logic [30:0] hs    [0:HORNER];
  logic [30:0] hc    [0:HORNER];
  trig_side_t  t1;

  always_ff @(posedge clk) begin
    t1.x    <= t0.x;
    t1.x2   <= xx[59:30];
    t1.swap <= t0.swap;
    t1.quad <= t0.quad;
    t1.sinq <= t0.sinq;
    t1.ycl  <= t0.ycl;
  end

  assign hv[0]    = t1_v;
  assign hside[0] = t1;
  assign hs[0]    = ONE_TRIG;
  assign hc[0]    = ONE_TRIG;

  for (genvar i = 0; i < HORNER; i++) begin : g_horner
    logic        mv;
    trig_side_t  mside;
    logic [29:0] mys, myc;
    logic [60:0] ps, pc;
    logic [61:0] qc;
    logic [30:0] sn, cn;

    always_comb begin
      pc = hside[i].x2 * hc[i];
      qc = myc * COS_M[i];
      cn = ONE_TRIG - 31'(qc >> COS_K[i]);
    end

    if (i < HORNER - 1) begin : g_sin
      logic [61:0] qs;
      always_comb begin
        ps = hside[i].x2 * hs[i];
        qs = mys * SIN_M[i];
        sn = ONE_TRIG - 31'(qs >> SIN_K[i]);
      end
    end else begin : g_last
      // last step: multiply by x to finish the sine
      always_comb begin
        ps = hside[i].x * hs[i];
        sn = {1'b0, mys};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mv      <= 1'b0;
        hv[i+1] <= 1'b0;
      end else begin
        mv      <= hv[i];
        hv[i+1] <= mv;
      end
    end

    always_ff @(posedge clk) begin
      mside      <= hside[i];
      mys        <= ps[59:30];
      myc        <= pc[59:30];
      hside[i+1] <= mside;
      hs[i+1]    <= sn;
      hc[i+1]    <= cn;
    end
  end

  // ---- unfold by quadrant and scale by sin_theta
  logic [30:0] bc, bs, mx, mz;
  logic        nx, nz;
  logic        p_v;
  logic [46:0] p_x, p_z;
  logic        p_nx, p_nz;
  logic [14:0] p_y;
  trig_side_t  hl;

  assign hl = hside[HORNER];

  always_comb begin
    bc = hl.swap ? hs[HORNER] : hc[HORNER];
    bs = hl.swap ? hc[HORNER] : hs[HORNER];
    unique case (hl.quad)
      2'd0: begin mx = bc; nx = 1'b0; mz = bs; nz = 1'b0; end
      2'd1: begin mx = bs; nx = 1'b1; mz = bc; nz = 1'b0; end
      2'd2: begin mx = bc; nx = 1'b1; mz = bs; nz = 1'b1; end
      default: begin mx = bs; nx = 1'b0; mz = bc; nz = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v  <= 1'b0;
      done <= 1'b0;
    end else begin
      p_v  <= hv[HORNER];
      done <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    p_x   <= hl.sinq * mx;
    p_z   <= hl.sinq * mz;
    p_nx  <= nx;
    p_nz  <= nz;
    p_y   <= hl.ycl;
    dir_x <= sat_out(p_x, p_nx);
    dir_z <= sat_out(p_z, p_nz);
    dir_y <= p_y;
  end

  // ---- checks
  `ASSERT_IMPLY(a_latency, clk, rst, done, $past(start, LATENCY))
  `ASSERT_IMPLY(a_div_rem, clk, rst, dv[DIV_STEPS] && !dz[DIV_STEPS], dr[DIV_STEPS] < 18'(dd[DIV_STEPS]))
  `ASSERT_IMPLY(a_cos_range, clk, rst, q1_v && !side1[16], root1 <= ONE_OUT)

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GGX hemisphere sampler. A directed table, then
// random words, are sent with random gaps. Every accepted word goes through a
// bit-exact fixed-point direction predictor. Each strobed result is compared
// with the oldest predicted direction, or with its hand-typed row if typed.
// ----------------------------------------------------------------------------
module tb_top import ggx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] x;
    logic [14:0]        y;
    logic signed [15:0] z;
  } dir_t;

  typedef struct {
    logic [15:0] ang;
    logic [16:0] hgt;
    logic [16:0] rgh;
    bit          typed;
    dir_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] rand_angle = '0;
  logic [16:0] rand_height = '0;
  logic [16:0] surface_roughness = '0;
  logic done;
  logic signed [15:0] dir_x;
  logic [14:0] dir_y;
  logic signed [15:0] dir_z;

  // newest at the front, oldest at the back
  dir_t pending_dirs[$];
  dir_t typed_dirs[$];
  bit   typed_flags[$];
  bit   next_typed = 1'b0;
  dir_t next_want;
  int   errors = 0;

  ggx_hemisphere_sampler i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .rand_angle(rand_angle), .rand_height(rand_height),
    .surface_roughness(surface_roughness),
    .done(done), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // cos and sin of a 32-bit turn fraction, Q1.30
  function automatic void turn_cos_sin(input longint unsigned a32,
                                       output longint cs, output longint sn);
    longint unsigned sdiv [0:4];
    longint unsigned cdiv [0:5];
    longint unsigned one, t, x, x2, acc, s, c, tmp;
    longint unsigned quad;
    bit swap;
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    one = 64'd1 << 30;
    quad = (a32 >> 30) & 3;
    t = a32 & (one - 1);
    swap = t > (one >> 1);
    if (swap) t = one - t;
    x = (t * 64'(TWO_PI) + (64'd1 << 31)) >> 32;
    x2 = (x * x) >> 30;
    acc = one;
    for (int i = 0; i < 5; i++) acc = one - ((x2 * acc) >> 30) / sdiv[i];
    s = (x * acc) >> 30;
    acc = one;
    for (int i = 0; i < 6; i++) acc = one - ((x2 * acc) >> 30) / cdiv[i];
    c = acc;
    if (swap) begin
      tmp = s; s = c; c = tmp;
    end
    case (quad)
      0: begin cs = c;  sn = s;  end
      1: begin cs = -s; sn = c;  end
      2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  // round half away from zero to Q1.15, saturate
  function automatic logic [15:0] scale_q15(input longint unsigned mag, input longint trig);
    bit neg;
    longint unsigned m, p;
    longint v;
    neg = trig < 0;
    m = neg ? longint'(-trig) : longint'(trig);
    p = (mag * m + (64'd1 << 29)) >> 30;
    if (p > (64'd1 << 16)) p = 64'd1 << 16;
    v = neg ? -longint'(p) : longint'(p);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic dir_t predict_dir(input logic [15:0] ang, input logic [16:0] hgt,
                                       input logic [16:0] rgh);
    longint unsigned one, r2, g, al, al2, num, den, q, rem, cosq, s2, cc;
    longint cphi, sphi;
    dir_t d;
    one = 64'd1 << 16;
    r2 = hgt > one ? one : hgt;
    g = rgh > one ? one : rgh;
    al = (g * g) >> 16;
    al2 = (al * al) >> 16;
    num = one - r2;
    den = one - (((one - al2) * r2) >> 16);
    if (den == 0) begin
      cosq = 64'd1 << 15;
    end else begin
      q = 0;
      rem = num;
      if (rem >= den) begin
        q = 1;
        rem -= den;
      end
      for (int i = 0; i < 30; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
      cosq = int_sqrt(q);
      if (cosq > (64'd1 << 15)) cosq = 64'd1 << 15;
    end
    cc = cosq * cosq;
    s2 = (64'd1 << 30) > cc ? (64'd1 << 30) - cc : 0;
    turn_cos_sin(longint'(ang) << 16, cphi, sphi);
    d.x = scale_q15(int_sqrt(s2), cphi);
    d.y = cosq >= (64'd1 << 15) ? YMAX : cosq[14:0];
    d.z = scale_q15(int_sqrt(s2), sphi);
    return d;
  endfunction

  // capture each accepted word
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pending_dirs.push_front(predict_dir(rand_angle, rand_height, surface_roughness));
      typed_flags.push_front(next_typed);
      typed_dirs.push_front(next_want);
    end
  end

  always @(posedge clk) begin
    dir_t exp_d;
    dir_t tw;
    bit   tf;
    if (!rst && done) begin
      if (pending_dirs.size() == 0) begin
        $error("result with no word outstanding");
        errors++;
      end else begin
        exp_d = pending_dirs.pop_back();
        tf = typed_flags.pop_back();
        tw = typed_dirs.pop_back();
        // a hand-typed row overrides the predictor
        if (tf) exp_d = tw;
        if (dir_x !== exp_d.x) begin
          $error("dir_x expected %0d actual %0d", exp_d.x, dir_x);
          errors++;
        end
        if (dir_y !== exp_d.y) begin
          $error("dir_y expected %0d actual %0d", exp_d.y, dir_y);
          errors++;
        end
        if (dir_z !== exp_d.z) begin
          $error("dir_z expected %0d actual %0d", exp_d.z, dir_z);
          errors++;
        end
      end
    end
  end

  task automatic send_word(input logic [15:0] a, input logic [16:0] h, input logic [16:0] g,
                           input bit typed, input dir_t want);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    rand_angle <= a;
    rand_height <= h;
    surface_roughness <= g;
    next_typed <= typed;
    next_want <= want;
    do @(posedge clk); while (busy);
  endtask

  stim_row_t rows [] = '{
    '{16'h0000, 17'h00000, 17'h08000, 1'b1, '{16'sd0, 15'd32767, 16'sd0}},
    '{16'h1234, 17'h10000, 17'h00000, 1'b1, '{16'sd0, 15'd32767, 16'sd0}},
    '{16'h0000, 17'h10000, 17'h10000, 1'b1, '{16'sd32767, 15'd0, 16'sd0}},
    '{16'h4000, 17'h10000, 17'h10000, 1'b1, '{16'sd0, 15'd0, 16'sd32767}},
    '{16'h8000, 17'h10000, 17'h10000, 1'b1, '{-16'sd32768, 15'd0, 16'sd0}},
    '{16'hC000, 17'h10000, 17'h10000, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'hFFFF, 17'h1FFFF, 17'h1FFFF, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h2000, 17'h08000, 17'h10000, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h6000, 17'h08000, 17'h00000, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'hA000, 17'h0FFFF, 17'h00001, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'hE000, 17'h00001, 17'h0FFFF, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h1555, 17'h1FFFF, 17'h00000, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h5555, 17'h04000, 17'h1FFFF, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h9999, 17'h0C000, 17'h04000, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h7FFF, 17'h0FFFF, 17'h00100, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h8001, 17'h10000, 17'h00080, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'h3FFF, 17'h00010, 17'h10000, 1'b0, '{16'sd0, 15'd0, 16'sd0}},
    '{16'hC001, 17'h0F000, 17'h02000, 1'b0, '{16'sd0, 15'd0, 16'sd0}}
  };

  function automatic logic [16:0] rand_unit();
    case ($urandom_range(0, 7))
      0: return 17'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? ONE_IN : 17'd0;
      2: return 17'($urandom_range(65500, 65536));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    dir_t none;
    none = '{16'sd0, 15'd0, 16'sd0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      send_word(rows[i].ang, rows[i].hgt, rows[i].rgh, rows[i].typed, rows[i].want);
    repeat (450) send_word(16'($urandom), rand_unit(), rand_unit(), 1'b0, none);
    start <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
